### design/tss_pkg.sv
package tss_pkg;

    // Default number of table points
    localparam int TABLE_DEPTH_DEF = 256;

    // Fixed field widths
    localparam int ENERGY_W  = 20;
    localparam int DENSITY_W = 16;
    localparam int FRAC_W    = 32;
    localparam int CUM_W     = 48;
    localparam int HELD_W    = 9;

    // Quotient bits of the interpolation divide (one per energy bit)
    localparam int DIV_STEPS = ENERGY_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOT_INCR = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_MUL,
        S_SUM,
        S_SRCH,
        S_SCMP,
        S_PICK,
        S_GPREV,
        S_GCUR,
        S_PROD0,
        S_PROD1,
        S_DIVST,
        S_DIV,
        S_DIVFIN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_in;
        logic do_load;
        logic clear;
        logic set_empty;
        logic mul;
        logic sum;
        logic srch_rd;
        logic srch_cmp;
        logic zero_prev;
        logic rd_prev;
        logic got_prev;
        logic rd_cur;
        logic got_cur;
        logic prod0;
        logic prod1;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       srch_done;
        logic       found;
        logic       first;
        logic       div_done;
    } t_dp_sts;

endpackage

### design/tabulated_spectrum_sampler_core.sv
// Channel   Direction  Bus fields (low bit first)
// s_axis    in         tdata: point_energy[19:0], point_density[35:20],
//                             uniform_fraction[67:36], zero[71:68]; tuser: op
// m_axis    out        tdata: sampled_energy[19:0], points_held[28:20],
//                             zero[31:29]; tuser: status
//
// A load passes through S_LOAD; clear, invalid ops and a sample on an empty table
// go from S_DISPATCH straight to S_DONE. A sample runs a binary search over the
// cumulative memory, one registered read per probe (picking the first interval
// skips the previous-point read), then a 20-step restoring divide for the
// interpolation. A stall on m_axis holds the core in S_DONE until the output is free.
// Reset is synchronous, active low, and empties the table; memories are not
// cleared. A new transaction is taken while a result waits on m_axis.
module tabulated_spectrum_sampler_core
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // point_energy, point_density, uniform_fraction
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // sampled_energy, points_held
    output logic [1:0]  m_axis_tuser   // status
);

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [ENERGY_W-1:0] w_energy;
    logic [HELD_W-1:0]   w_held;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tss_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_op               (s_axis_tuser),
        .i_point_energy     (s_axis_tdata[19:0]),
        .i_point_density    (s_axis_tdata[35:20]),
        .i_uniform_fraction (s_axis_tdata[67:36]),
        .o_sampled_energy   (w_energy),
        .o_points_held      (w_held),
        .o_status           (m_axis_tuser)
    );

    assign m_axis_tdata = {3'd0, w_held, w_energy};

endmodule

### design/tss_ram.sv
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/tss_datapath.sv
module tss_datapath
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [1:0]           i_op,
    input  logic [ENERGY_W-1:0]  i_point_energy,
    input  logic [DENSITY_W-1:0] i_point_density,
    input  logic [FRAC_W-1:0]    i_uniform_fraction,
    output logic [ENERGY_W-1:0]  o_sampled_energy,
    output logic [HELD_W-1:0]    o_points_held,
    output logic [1:0]           o_status
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = CUM_W + 1;
    localparam int AXW = CUM_W + ENERGY_W;

    logic [1:0]           r_op;
    logic [ENERGY_W-1:0]  r_e;
    logic [DENSITY_W-1:0] r_d;
    logic [FRAC_W-1:0]    r_u;
    logic [CW-1:0]        r_count;
    logic [ENERGY_W-1:0]  r_last_e;
    logic [CUM_W-1:0]     r_total;
    logic [CUM_W-1:0]     r_ph;
    logic [2*FRAC_W-1:0]  r_pl;
    logic [PW-1:0]        r_p;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CUM_W-1:0]     r_prev;
    logic [ENERGY_W-1:0]  r_e0;
    logic [ENERGY_W-1:0]  r_de;
    logic [CUM_W-1:0]     r_num;
    logic [CUM_W-1:0]     r_dp;
    logic [AXW-1:0]       r_acc;
    logic [CUM_W-1:0]     r_rem;
    logic [ENERGY_W-1:0]  r_q;
    logic [4:0]           r_div_cnt;
    logic [ENERGY_W-1:0]  r_res_e;
    t_status              r_res_st;
    logic [ENERGY_W-1:0]  r_out_e;
    logic [HELD_W-1:0]    r_out_n;
    t_status              r_out_st;

    logic                 w_full;
    logic                 w_not_incr;
    logic                 w_load_ok;
    logic [ENERGY_W-1:0]  w_step;
    logic [CUM_W-1:0]     w_base;
    logic [DENSITY_W+ENERGY_W-1:0] w_area;
    logic [CUM_W-1:0]     w_new_c;
    logic [CW:0]          w_mid_sum;
    logic [CW-1:0]        w_mid;
    logic [CW-1:0]        w_lo_m1;
    logic [AW-1:0]        w_raddr;
    logic                 w_re;
    logic [CUM_W-1:0]     w_rd_c;
    logic [ENERGY_W-1:0]  w_rd_e;
    logic [43:0]          w_pp0;
    logic [43:0]          w_pp1;
    logic [PW-1:0]        w_trial;
    logic [PW-1:0]        w_trial_sub;

    // Load checks and new cumulative entry
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_not_incr = (r_count != '0) && (r_e <= r_last_e);
    assign w_load_ok  = i_cmd.do_load && !w_full && !w_not_incr;
    assign w_step     = (r_count == '0) ? r_e : (r_e - r_last_e);
    assign w_base     = (r_count == '0) ? '0 : r_total;
    assign w_area     = r_d * w_step;
    assign w_new_c    = w_base + CUM_W'(w_area);

    // Search midpoint and read address select
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[CW:1];
    assign w_lo_m1   = r_lo - 1'b1;
    assign w_re      = i_cmd.srch_rd || i_cmd.rd_prev || i_cmd.rd_cur;

    always_comb begin
        if (i_cmd.srch_rd) begin
            w_raddr = w_mid[AW-1:0];
        end else if (i_cmd.rd_prev) begin
            w_raddr = w_lo_m1[AW-1:0];
        end else begin
            w_raddr = r_lo[AW-1:0];
        end
    end

    tss_ram #(.WIDTH(CUM_W), .DEPTH(TABLE_DEPTH)) u_cum_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_new_c),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_c)
    );

    tss_ram #(.WIDTH(ENERGY_W), .DEPTH(TABLE_DEPTH)) u_energy_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_e),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_e)
    );

    // Interpolation products and divide step
    assign w_pp0       = r_num[23:0] * r_de;
    assign w_pp1       = r_num[47:24] * r_de;
    assign w_trial     = {r_rem, r_acc[ENERGY_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_dp};

    // Point count, the only register here with a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (w_load_ok) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op     <= i_op;
            r_e      <= i_point_energy;
            r_d      <= i_point_density;
            r_u      <= i_uniform_fraction;
            r_res_e  <= '0;
            r_res_st <= ST_OK;
        end
        if (i_cmd.do_load) begin
            if (w_full) begin
                r_res_st <= ST_FULL;
            end else if (w_not_incr) begin
                r_res_st <= ST_NOT_INCR;
            end else begin
                r_last_e <= r_e;
                r_total  <= w_new_c;
            end
        end
        if (i_cmd.set_empty) begin
            r_res_st <= ST_EMPTY;
        end
        if (i_cmd.mul) begin
            r_ph <= r_u * r_total[CUM_W-1:FRAC_W];
            r_pl <= r_u * r_total[FRAC_W-1:0];
        end
        if (i_cmd.sum) begin
            r_p  <= PW'(r_ph) + PW'(r_pl[2*FRAC_W-1:FRAC_W]);
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.srch_cmp) begin
            if (PW'(w_rd_c) > r_p) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + 1'b1;
            end
        end
        if (i_cmd.zero_prev) begin
            r_prev <= '0;
            r_e0   <= '0;
        end
        if (i_cmd.got_prev) begin
            r_prev <= w_rd_c;
            r_e0   <= w_rd_e;
        end
        if (i_cmd.got_cur) begin
            r_de  <= w_rd_e - r_e0;
            r_num <= CUM_W'(r_p - PW'(r_prev));
            r_dp  <= w_rd_c - r_prev;
        end
        if (i_cmd.prod0) begin
            r_acc <= {24'd0, w_pp0};
        end
        if (i_cmd.prod1) begin
            r_acc <= r_acc + {w_pp1, 24'd0};
        end
        if (i_cmd.div_init) begin
            r_rem     <= r_acc[AXW-1:ENERGY_W];
            r_q       <= '0;
            r_div_cnt <= 5'(DIV_STEPS);
        end
        if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_dp}) begin
                r_rem <= w_trial_sub[CUM_W-1:0];
                r_q   <= {r_q[ENERGY_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[CUM_W-1:0];
                r_q   <= {r_q[ENERGY_W-2:0], 1'b0};
            end
            r_acc     <= r_acc << 1;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.div_fin) begin
            r_res_e <= r_e0 + r_q;
        end
        if (i_cmd.out_load) begin
            r_out_e  <= r_res_e;
            r_out_n  <= HELD_W'(r_count);
            r_out_st <= r_res_st;
        end
    end

    // Status toward the controller
    assign o_sts.op        = r_op;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.srch_done = !(r_lo < r_hi);
    assign o_sts.found     = (r_lo < r_count);
    assign o_sts.first     = (r_lo == '0);
    assign o_sts.div_done  = (r_div_cnt == '0);

    assign o_sampled_energy = r_out_e;
    assign o_points_held    = r_out_n;
    assign o_status         = r_out_st;

endmodule

### design/tss_ctrl.sv
module tss_ctrl
    import tss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (t_op'(i_sts.op))
                    OP_LOAD:   n_state = S_LOAD;
                    OP_SAMPLE: n_state = i_sts.empty ? S_DONE : S_MUL;
                    default:   n_state = S_DONE;
                endcase
            end
            S_LOAD:   n_state = S_DONE;
            S_MUL:    n_state = S_SUM;
            S_SUM:    n_state = S_SRCH;
            S_SRCH:   n_state = i_sts.srch_done ? S_PICK : S_SCMP;
            S_SCMP:   n_state = S_SRCH;
            S_PICK: begin
                if (!i_sts.found) begin
                    n_state = S_DONE;
                end else if (i_sts.first) begin
                    n_state = S_GCUR;
                end else begin
                    n_state = S_GPREV;
                end
            end
            S_GPREV:  n_state = S_GCUR;
            S_GCUR:   n_state = S_PROD0;
            S_PROD0:  n_state = S_PROD1;
            S_PROD1:  n_state = S_DIVST;
            S_DIVST:  n_state = S_DIV;
            S_DIV:    n_state = i_sts.div_done ? S_DIVFIN : S_DIV;
            S_DIVFIN: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.clear     = (t_op'(i_sts.op) == OP_CLEAR);
                o_cmd.set_empty = (t_op'(i_sts.op) == OP_SAMPLE) && i_sts.empty;
            end
            S_LOAD:   o_cmd.do_load  = 1'b1;
            S_MUL:    o_cmd.mul      = 1'b1;
            S_SUM:    o_cmd.sum      = 1'b1;
            S_SRCH:   o_cmd.srch_rd  = !i_sts.srch_done;
            S_SCMP:   o_cmd.srch_cmp = 1'b1;
            S_PICK: begin
                o_cmd.zero_prev = i_sts.found && i_sts.first;
                o_cmd.rd_cur    = i_sts.found && i_sts.first;
                o_cmd.rd_prev   = i_sts.found && !i_sts.first;
            end
            S_GPREV: begin
                o_cmd.got_prev = 1'b1;
                o_cmd.rd_cur   = 1'b1;
            end
            S_GCUR:   o_cmd.got_cur  = 1'b1;
            S_PROD0:  o_cmd.prod0    = 1'b1;
            S_PROD1:  o_cmd.prod1    = 1'b1;
            S_DIVST:  o_cmd.div_init = 1'b1;
            S_DIV:    o_cmd.div_step = !i_sts.div_done;
            S_DIVFIN: o_cmd.div_fin  = 1'b1;
            S_DONE:   o_cmd.out_load = w_out_free;
            default:  o_cmd = '0;
        endcase
    end

    // Hold the result until the downstream side takes it
    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
